>>> rtl/core/bn_pkg.sv
// bn_pkg: shared types and constants for the batch-normalization block
// used by bn_ctrl, bn_dp and batchnorm_inference_top
package bn_pkg;

    localparam logic [0:0] CFG_CHANNEL_COUNT = 1'b0;
    localparam logic [0:0] CFG_EPSILON       = 1'b1;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic [1:0] SEL_GAMMA = 2'd0;
    localparam logic [1:0] SEL_BETA  = 2'd1;
    localparam logic [1:0] SEL_MEAN  = 2'd2;
    localparam logic [1:0] SEL_VAR   = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_OUT
    } bn_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic sqrt_init;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic mul_lo;
        logic mul_hi;
        logic sum;
    } bn_cmd_t;

endpackage

>>> rtl/core/bn_ram.sv
// bn_ram: generic single-port write, single-port registered read ram
// depends on nothing
module bn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/bn_ctrl.sv
// bn_ctrl: sequencer for clear sweep, root, divide, multiply and output
// depends on bn_pkg
module bn_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear_done,
    input  logic              sample_take,
    input  logic              out_taken,
    input  logic [5:0]        step_cnt,
    output bn_pkg::bn_cmd_t   cmd,
    output bn_pkg::bn_state_t state,
    output logic              step_clr
);

    bn_pkg::bn_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bn_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bn_pkg::ST_CLEAR:     if (clear_done) state_next = bn_pkg::ST_IDLE;
            bn_pkg::ST_IDLE:      if (sample_take) state_next = bn_pkg::ST_READ;
            bn_pkg::ST_READ:      state_next = bn_pkg::ST_SQRT_INIT;
            bn_pkg::ST_SQRT_INIT: state_next = bn_pkg::ST_SQRT;
            bn_pkg::ST_SQRT:      if (step_cnt == 6'd24) state_next = bn_pkg::ST_DIV_INIT;
            bn_pkg::ST_DIV_INIT:  state_next = bn_pkg::ST_DIV;
            bn_pkg::ST_DIV:       if (step_cnt == 6'd48) state_next = bn_pkg::ST_MUL_LO;
            bn_pkg::ST_MUL_LO:    state_next = bn_pkg::ST_MUL_HI;
            bn_pkg::ST_MUL_HI:    state_next = bn_pkg::ST_SUM;
            bn_pkg::ST_SUM:       state_next = bn_pkg::ST_OUT;
            bn_pkg::ST_OUT:       if (out_taken) state_next = bn_pkg::ST_IDLE;
            default:              state_next = bn_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        step_clr = 1'b0;
        case (state_reg)
            bn_pkg::ST_READ:      cmd.capture = 1'b1;
            bn_pkg::ST_SQRT_INIT:
            begin
                cmd.sqrt_init = 1'b1;
                step_clr      = 1'b1;
            end
            bn_pkg::ST_SQRT:      cmd.sqrt_step = 1'b1;
            bn_pkg::ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                step_clr     = 1'b1;
            end
            bn_pkg::ST_DIV:       cmd.div_step = 1'b1;
            bn_pkg::ST_MUL_LO:    cmd.mul_lo = 1'b1;
            bn_pkg::ST_MUL_HI:    cmd.mul_hi = 1'b1;
            bn_pkg::ST_SUM:       cmd.sum = 1'b1;
            default:              cmd = '0;
        endcase
    end

    assign state = state_reg;

endmodule

>>> rtl/core/bn_dp.sv
// bn_dp: arithmetic datapath: bit-serial root, restoring divide, split multiply
// depends on bn_pkg
module bn_dp (
    input  logic             clk,
    input  bn_pkg::bn_cmd_t  cmd,
    input  logic [31:0]      sample,
    input  logic [15:0]      epsilon,
    input  logic [31:0]      gamma_rd,
    input  logic [31:0]      beta_rd,
    input  logic [31:0]      mean_rd,
    input  logic [31:0]      var_rd,
    output logic [31:0]      result,
    output logic             sat
);

    logic signed [32:0] diff_reg;
    logic signed [32:0] gam_reg;
    logic signed [31:0] beta_reg;
    logic [33:0]        s_reg;
    logic [49:0]        rem_sq_reg;
    logic [49:0]        res_reg;
    logic [49:0]        bit_reg;
    logic [48:0]        num_reg;
    logic [24:0]        drem_reg;
    logic [40:0]        q_reg;
    logic               qneg_reg;
    logic               gneg_reg;
    logic [31:0]        ug_reg;
    logic [63:0]        lo_reg;
    logic [56:0]        shifted_reg;
    logic               rembit_reg;
    logic [31:0]        result_reg;
    logic               sat_reg;

    logic signed [33:0] s_raw;
    logic [49:0]        rb;
    logic [24:0]        d_root;
    logic [25:0]        trial;
    logic [32:0]        udiff;
    logic [8:0]         ah;
    logic [40:0]        hi_prod;
    logic               pneg;
    logic signed [58:0] p_val;
    logic signed [58:0] y_val;

    // variance sum, floored at one lsb
    always_comb
    begin
        s_raw = 34'(signed'(var_rd)) +
                34'((epsilon == 16'd0) ? 16'd1 : epsilon);
        rb    = res_reg + bit_reg;
        d_root = 25'(res_reg);
        if (d_root == 25'd0) d_root = 25'd1;
        trial  = {drem_reg, num_reg[48]} - {1'b0, d_root};
        udiff  = diff_reg[32] ? 33'(-diff_reg) : 33'(diff_reg);
        ah     = q_reg[40:32];
        hi_prod = 41'(ah) * 41'(ug_reg);
        pneg   = (qneg_reg != gneg_reg) && (q_reg != 41'd0) && (ug_reg != 32'd0);
        p_val  = pneg ? -59'(shifted_reg + 57'(rembit_reg)) : 59'(shifted_reg);
        y_val  = p_val + 59'(beta_reg);
    end

    // sequenced arithmetic registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            diff_reg <= 33'(signed'(sample)) - 33'(signed'(mean_rd));
            gam_reg  <= 33'(signed'(gamma_rd));
            beta_reg <= signed'(beta_rd);
            s_reg    <= (s_raw < 34'sd1) ? 34'd1 : 34'(s_raw);
        end
        if (cmd.sqrt_init)
        begin
            rem_sq_reg <= {s_reg, 16'd0};
            res_reg    <= '0;
            bit_reg    <= 50'd1 << 48;
            qneg_reg   <= diff_reg[32];
            gneg_reg   <= gam_reg[32];
            ug_reg     <= gam_reg[32] ? 32'(-gam_reg) : 32'(gam_reg);
        end
        if (cmd.sqrt_step)
        begin
            if (rem_sq_reg >= rb)
            begin
                rem_sq_reg <= rem_sq_reg - rb;
                res_reg    <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.div_init)
        begin
            num_reg  <= {udiff, 16'd0};
            drem_reg <= '0;
            q_reg    <= '0;
        end
        if (cmd.div_step)
        begin
            num_reg <= num_reg << 1;
            if (!trial[25])
            begin
                drem_reg <= trial[24:0];
                q_reg    <= {q_reg[39:0], 1'b1};
            end
            else
            begin
                drem_reg <= {drem_reg[23:0], num_reg[48]};
                q_reg    <= {q_reg[39:0], 1'b0};
            end
        end
        if (cmd.mul_lo)
        begin
            lo_reg <= 64'(q_reg[31:0]) * 64'(ug_reg);
        end
        if (cmd.mul_hi)
        begin
            shifted_reg <= {hi_prod, 16'd0} + 57'(lo_reg[63:16]);
            rembit_reg  <= lo_reg[15:0] != 16'd0;
        end
        if (cmd.sum)
        begin
            if (y_val > 59'sd2147483647)
            begin
                result_reg <= 32'h7fff_ffff;
                sat_reg    <= 1'b1;
            end
            else if (y_val < -59'sd2147483648)
            begin
                result_reg <= 32'h8000_0000;
                sat_reg    <= 1'b1;
            end
            else
            begin
                result_reg <= y_val[31:0];
                sat_reg    <= 1'b0;
            end
        end
    end

    assign result = result_reg;
    assign sat    = sat_reg;

endmodule

>>> rtl/core/batchnorm_inference_top.sv
// batchnorm_inference_top: per-channel batch-normalization inference, Q16.16
// depends on bn_pkg, bn_ram, bn_ctrl, bn_dp
//
// Input stream s_axis: one transfer per item. A load item (func 0) writes one
// entry of the gamma, beta, mean or variance table and gives no
// result. A sample item (func 1) takes its channel from an internal counter
// that wraps at channel_count and gives one transfer on m_axis.
// A sample passes from acceptance to output valid through a table
// read, a 25-step bit-serial square root, a 49-step restoring divider, a
// low and a high multiply step and a sum/saturate step. One sample is in
// work at a time; a new sample is taken only after the last result is taken.
// tlast marks the last channel of a row; m_axis_tuser flags saturation.
// Configuration is written through cfg_valid/cfg_ready with index and data;
// writing channel_count restarts the channel counter.
// After reset a clearing pass zeroes every entry of all four tables; s_axis
// is held not ready during it. When m_axis_tready is low the result waits
// in its output register and s_axis stays not ready until it moves.
module batchnorm_inference_top #(
    parameter int MAX_CHANNELS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] param_channel, [39:8] data_value
    input  logic [39:0] s_axis_tdata,
    // [0] func, [2:1] param_select
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] normalized_value, [39:32] channel_index
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // [0] saturated
    output logic        m_axis_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CW = $clog2(MAX_CHANNELS + 1);

    logic              func;
    logic [1:0]        psel;
    logic [7:0]        pch;
    logic [31:0]       dval;
    logic [8:0]        cnt_reg;
    logic [15:0]       eps_reg;
    logic [CW-1:0]     pos_reg;
    logic [AW:0]       clr_reg;
    logic [31:0]       x_reg;
    logic [7:0]        ch_reg;
    logic              last_reg;
    logic [5:0]        step_reg;
    logic              step_clr;
    bn_pkg::bn_cmd_t   cmd;
    bn_pkg::bn_state_t state;
    logic              idle;
    logic              clearing;
    logic              take;
    logic              load_we;
    logic [CW-1:0]     eff_cnt;
    logic [CW-1:0]     cur_ch;
    logic [AW-1:0]     waddr;
    logic [31:0]       wdata;
    logic [3:0]        we;
    logic [31:0]       rd [4];
    logic [31:0]       result;
    logic              sat;

    assign func = s_axis_tuser[0];
    assign psel = s_axis_tuser[2:1];
    assign pch  = s_axis_tdata[7:0];
    assign dval = s_axis_tdata[39:8];

    assign clearing      = (state == bn_pkg::ST_CLEAR);
    assign idle          = (state == bn_pkg::ST_IDLE);
    assign s_axis_tready = idle;
    assign cfg_ready     = 1'b1;
    assign take    = s_axis_tvalid && idle && (func == bn_pkg::FUNC_SAMPLE);
    assign load_we = s_axis_tvalid && idle && (func == bn_pkg::FUNC_LOAD) &&
                     (32'(pch) < 32'(MAX_CHANNELS));

    // effective channel count and current channel
    always_comb
    begin
        if (cnt_reg == 9'd0)
            eff_cnt = CW'(1);
        else if (32'(cnt_reg) > 32'(MAX_CHANNELS))
            eff_cnt = CW'(MAX_CHANNELS);
        else
            eff_cnt = CW'(cnt_reg);
        cur_ch = (pos_reg >= eff_cnt) ? '0 : pos_reg;
    end

    // table write port, shared with the clearing sweep
    always_comb
    begin
        waddr = clearing ? clr_reg[AW-1:0] : AW'(pch);
        wdata = clearing ? 32'd0 : dval;
        we    = '0;
        if (clearing)
            we = 4'hf;
        else if (load_we)
            we[psel] = 1'b1;
    end

    // configuration, channel counter, clear sweep and sample capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 9'd1;
            eps_reg  <= 16'd1;
            pos_reg  <= '0;
            clr_reg  <= '0;
            last_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            if (clearing)
                clr_reg <= clr_reg + 1'b1;
            if (step_clr)
                step_reg <= '0;
            else
                step_reg <= step_reg + 1'b1;
            if (take)
            begin
                last_reg <= (cur_ch + 1'b1 >= eff_cnt);
                pos_reg  <= (cur_ch + 1'b1 >= eff_cnt) ? '0 : cur_ch + 1'b1;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    bn_pkg::CFG_CHANNEL_COUNT:
                    begin
                        cnt_reg <= cfg_data[8:0];
                        pos_reg <= '0;
                    end
                    bn_pkg::CFG_EPSILON: eps_reg <= cfg_data;
                    default:             eps_reg <= eps_reg;
                endcase
            end
        end
    end

    // sample payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            x_reg  <= dval;
            ch_reg <= 8'(cur_ch);
        end
    end

    // four parameter tables
    for (genvar g = 0; g < 4; g++)
    begin : g_tbl
        bn_ram #(.WIDTH(32), .DEPTH(MAX_CHANNELS)) u_ram (
            .clk   (clk),
            .we    (we[g]),
            .waddr (waddr),
            .wdata (wdata),
            .raddr (AW'(cur_ch)),
            .rdata (rd[g])
        );
    end

    bn_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear_done  (clr_reg == (AW+1)'(MAX_CHANNELS - 1)),
        .sample_take (take),
        .out_taken   (m_axis_tready),
        .step_cnt    (step_reg),
        .cmd         (cmd),
        .state       (state),
        .step_clr    (step_clr)
    );

    bn_dp u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .sample   (x_reg),
        .epsilon  (eps_reg),
        .gamma_rd (rd[bn_pkg::SEL_GAMMA]),
        .beta_rd  (rd[bn_pkg::SEL_BETA]),
        .mean_rd  (rd[bn_pkg::SEL_MEAN]),
        .var_rd   (rd[bn_pkg::SEL_VAR]),
        .result   (result),
        .sat      (sat)
    );

    assign m_axis_tvalid = (state == bn_pkg::ST_OUT);
    assign m_axis_tdata  = {ch_reg, result};
    assign m_axis_tlast  = last_reg;
    assign m_axis_tuser  = sat;

endmodule
